// ----- sv/mst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types, codes and defaults for the multi-slot software timer.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int SLOT_COUNT_DEF = 10;
	localparam int OP_W = 3;
	localparam int HANDLE_W = 8;
	localparam int DUR_W = 32;
	localparam int SLOT_W = 6;

	localparam logic [OP_W-1:0] OP_START_ONESHOT  = 3'd0;
	localparam logic [OP_W-1:0] OP_START_PERIODIC = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP           = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART        = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK           = 3'd4;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_EXPIRY = 2'd1,
		KIND_IDLE   = 2'd2
	} kind_t;

	typedef struct packed {
		logic  load_in;
		logic  clr_idx;
		logic  inc_idx;
		logic  clr_exp;
		logic  start_wr;
		logic  stop_wr;
		logic  restart_wr;
		logic  tick_wr;
		logic  out_load;
		kind_t out_kind;
		logic  out_ok;
		logic  out_last;
	} mst_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            match;
		logic            idx_last;
		logic            any_exp;
		logic            exp_bit;
		logic            more_exp;
		logic            out_free;
	} mst_stat_t;

endpackage
`default_nettype wire

// ----- sv/mst_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_datapath
// Slot table, walk index, expiry flags, captured command and output register.
// ----------------------------------------------------------------------------
module mst_datapath
	import mst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mst_cmd_t            cmd,
	output mst_stat_t                stat,
	input  wire logic [OP_W-1:0]     in_op,
	input  wire logic [HANDLE_W-1:0] in_handle,
	input  wire logic [DUR_W-1:0]    in_dur,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kind_t                    out_kind,
	output logic                     out_ok,
	output logic [HANDLE_W-1:0]      out_handle,
	output logic [SLOT_W-1:0]        out_slot,
	output logic                     out_last
);

	localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [HANDLE_W-1:0]   owner_q  [SLOT_COUNT];
	logic [DUR_W-1:0]      period_q [SLOT_COUNT];
	logic [DUR_W-1:0]      remain_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] repeat_q;
	logic [SLOT_COUNT-1:0] exp_q;
	logic [IdxW-1:0]       idx_q;
	logic [OP_W-1:0]       op_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [DUR_W-1:0]      dur_q;

	logic [HANDLE_W-1:0] key;
	logic [DUR_W-1:0]    cur_rem;
	logic                cur_expire;
	logic [SLOT_COUNT-1:0] above;

	assign key = (op_q == OP_START_ONESHOT || op_q == OP_START_PERIODIC) ? '0 : handle_q;
	assign cur_rem = remain_q[idx_q];
	assign cur_expire = (cur_rem == DUR_W'(1));
	assign above = (exp_q >> idx_q) >> 1;

	assign stat.op       = op_q;
	assign stat.match    = (owner_q[idx_q] == key);
	assign stat.idx_last = (idx_q == IdxW'(SLOT_COUNT - 1));
	assign stat.any_exp  = (|exp_q) | cur_expire;
	assign stat.exp_bit  = exp_q[idx_q];
	assign stat.more_exp = |above;
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_op;
			handle_q <= in_handle;
			dur_q <= in_dur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			exp_q <= '0;
			repeat_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				owner_q[i] <= '0;
				period_q[i] <= '0;
				remain_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_q + IdxW'(1);
			end
			if (cmd.clr_exp) begin
				exp_q <= '0;
			end
			if (cmd.start_wr) begin
				owner_q[idx_q] <= handle_q;
				period_q[idx_q] <= dur_q;
				remain_q[idx_q] <= dur_q;
				repeat_q[idx_q] <= (op_q == OP_START_PERIODIC);
			end
			if (cmd.stop_wr) begin
				remain_q[idx_q] <= '0;
			end
			if (cmd.restart_wr) begin
				remain_q[idx_q] <= period_q[idx_q];
			end
			if (cmd.tick_wr && cur_rem != '0) begin
				if (cur_expire) begin
					exp_q[idx_q] <= 1'b1;
					remain_q[idx_q] <= repeat_q[idx_q] ? period_q[idx_q] : '0;
				end else begin
					remain_q[idx_q] <= cur_rem - DUR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind <= cmd.out_kind;
			out_ok <= cmd.out_ok;
			out_last <= cmd.out_last;
			out_handle <= (cmd.out_kind == KIND_EXPIRY) ? owner_q[idx_q] : '0;
			out_slot <= (cmd.out_ok || cmd.out_kind == KIND_EXPIRY) ? SLOT_W'(idx_q) : '0;
		end
	end

endmodule
`default_nettype wire

// ----- sv/mst_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer for slot searches, the tick walk and result beats.
// ----------------------------------------------------------------------------
module mst_ctrl
	import mst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output mst_cmd_t       cmd,
	input  wire mst_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FIND,
		S_TICK,
		S_EMIT,
		S_RESP
	} state_t;

	state_t state_q;
	logic   ok_q;
	kind_t  kind_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.out_kind = KIND_STATUS;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.clr_idx = 1'b1;
					cmd.clr_exp = 1'b1;
				end
			end
			S_DECODE: begin
			end
			S_FIND: begin
				if (stat.match) begin
					cmd.start_wr = (stat.op == OP_START_ONESHOT) ||
						(stat.op == OP_START_PERIODIC);
					cmd.stop_wr = (stat.op == OP_STOP);
					cmd.restart_wr = (stat.op == OP_RESTART);
				end else if (!stat.idx_last) begin
					cmd.inc_idx = 1'b1;
				end
			end
			S_TICK: begin
				cmd.tick_wr = 1'b1;
				if (stat.idx_last) begin
					cmd.clr_idx = 1'b1;
				end else begin
					cmd.inc_idx = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.out_kind = KIND_EXPIRY;
				cmd.out_last = !stat.more_exp;
				if (stat.exp_bit) begin
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.inc_idx = stat.more_exp;
					end
				end else begin
					cmd.inc_idx = 1'b1;
				end
			end
			S_RESP: begin
				cmd.out_kind = kind_q;
				cmd.out_ok = ok_q;
				cmd.out_last = 1'b1;
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q <= 1'b0;
			kind_q <= KIND_STATUS;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					ok_q <= 1'b0;
					kind_q <= KIND_STATUS;
					case (stat.op) inside
						OP_START_ONESHOT, OP_START_PERIODIC, OP_STOP, OP_RESTART: begin
							state_q <= S_FIND;
						end
						OP_TICK: begin
							state_q <= S_TICK;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_FIND: begin
					if (stat.match) begin
						ok_q <= 1'b1;
						state_q <= S_RESP;
					end else if (stat.idx_last) begin
						state_q <= S_RESP;
					end
				end
				S_TICK: begin
					if (stat.idx_last) begin
						if (stat.any_exp) begin
							state_q <= S_EMIT;
						end else begin
							kind_q <= KIND_IDLE;
							state_q <= S_RESP;
						end
					end
				end
				S_EMIT: begin
					if (stat.exp_bit && stat.out_free && !stat.more_exp) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/multi_slot_software_timer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_software_timer_top
// Table of one-shot and periodic timer slots driven by commands and ticks.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A start, stop or restart command walks
// the slot table one slot per cycle until the first free or matching slot is
// found or the last slot is checked, then sends its status beat. An unused
// code sends only a status beat. A tick walks every slot once to count down,
// then walks the slots again up to the last expired one to send one expiry
// beat per expired slot in slot order, or sends one idle beat when nothing
// expires. A stalled output holds the sequence until the beat is taken. The
// slot table is cleared by reset.
module multi_slot_software_timer_top
	import mst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // owner_handle[7:0], duration_ticks[39:8]
	input  wire logic [2:0]  s_tuser,  // opcode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // success[0], expired_handle[8:1], slot_number[14:9]
	output logic [1:0]       m_tuser,  // result_kind[1:0]
	output logic             m_tlast   // last_result
);

	mst_cmd_t            cmd;
	mst_stat_t           stat;
	kind_t               out_kind;
	logic                out_ok;
	logic [HANDLE_W-1:0] out_handle;
	logic [SLOT_W-1:0]   out_slot;

	mst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	mst_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tuser),
		.in_handle  (s_tdata[7:0]),
		.in_dur     (s_tdata[39:8]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_ok     (out_ok),
		.out_handle (out_handle),
		.out_slot   (out_slot),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {1'b0, out_slot, out_handle, out_ok};

endmodule
`default_nettype wire
